// File: src/tak_pkg.sv
// Shared types, constants and the step program for the tilt angle Kalman filter.
// Used by the filter top level and its multiply and divide units; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tak_pkg;

  localparam int unsigned W = 48;

  localparam logic signed [W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [W-1:0] MIN48 = 48'sh8000_0000_0000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_QA = 2'd0;
  localparam logic [1:0] CFG_QB = 2'd1;
  localparam logic [1:0] CFG_RM = 2'd2;

  localparam logic [23:0] QA_RESET = 24'd16777;
  localparam logic [23:0] QB_RESET = 24'd50332;
  localparam logic [23:0] RM_RESET = 24'd503316;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DONE
  } op_e;

  typedef enum logic [4:0] {
    SRC_NONE,
    SRC_ANG,
    SRC_BIAS,
    SRC_CAA,
    SRC_CAB,
    SRC_CBA,
    SRC_CBB,
    SRC_DT,
    SRC_T,
    SRC_U,
    SRC_Y,
    SRC_S,
    SRC_K0,
    SRC_K1,
    SRC_MEAS,
    SRC_RATE,
    SRC_QA,
    SRC_QB,
    SRC_RM
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e src_a;
    src_e src_b;
    src_e dst;
  } uop_t;

  // Request to a shared arithmetic unit.
  typedef struct packed {
    logic                start;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
  } unit_req_t;

  // Response from a shared arithmetic unit.
  typedef struct packed {
    logic                done;
    logic signed [W-1:0] value;
  } unit_rsp_t;

  // Saturate a 49-bit sum to the signed 48-bit range.
  function automatic logic signed [W-1:0] sat49(logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) begin
      r = v[W] ? MIN48 : MAX48;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a signed 48-bit value; the most negative value gives 2^47.
  function automatic logic [W-1:0] mag48(logic signed [W-1:0] v);
    logic [W-1:0] r;
    r = v[W-1] ? (W'(0) - W'(v)) : W'(v);
    return r;
  endfunction

  // Step program of one filter update: predict, gains, then correct in order.
  // The loop time dt is already in place when the program starts.
  function automatic uop_t uop_rom(logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = '{OP_SUB, SRC_RATE, SRC_BIAS,  SRC_T};
      5'd1:    u = '{OP_MUL, SRC_DT,   SRC_T,     SRC_T};
      5'd2:    u = '{OP_ADD, SRC_ANG,  SRC_T,     SRC_ANG};
      5'd3:    u = '{OP_MUL, SRC_DT,   SRC_CBB,   SRC_U};
      5'd4:    u = '{OP_SUB, SRC_U,    SRC_CAB,   SRC_T};
      5'd5:    u = '{OP_SUB, SRC_T,    SRC_CBA,   SRC_T};
      5'd6:    u = '{OP_ADD, SRC_T,    SRC_QA,    SRC_T};
      5'd7:    u = '{OP_MUL, SRC_DT,   SRC_T,     SRC_T};
      5'd8:    u = '{OP_ADD, SRC_CAA,  SRC_T,     SRC_CAA};
      5'd9:    u = '{OP_SUB, SRC_CAB,  SRC_U,     SRC_CAB};
      5'd10:   u = '{OP_SUB, SRC_CBA,  SRC_U,     SRC_CBA};
      5'd11:   u = '{OP_MUL, SRC_QB,   SRC_DT,    SRC_T};
      5'd12:   u = '{OP_ADD, SRC_CBB,  SRC_T,     SRC_CBB};
      5'd13:   u = '{OP_SUB, SRC_MEAS, SRC_ANG,   SRC_Y};
      5'd14:   u = '{OP_ADD, SRC_CAA,  SRC_RM,    SRC_S};
      5'd15:   u = '{OP_DIV, SRC_CAA,  SRC_S,     SRC_K0};
      5'd16:   u = '{OP_DIV, SRC_CBA,  SRC_S,     SRC_K1};
      5'd17:   u = '{OP_MUL, SRC_K0,   SRC_Y,     SRC_T};
      5'd18:   u = '{OP_ADD, SRC_ANG,  SRC_T,     SRC_ANG};
      5'd19:   u = '{OP_MUL, SRC_K1,   SRC_Y,     SRC_T};
      5'd20:   u = '{OP_ADD, SRC_BIAS, SRC_T,     SRC_BIAS};
      5'd21:   u = '{OP_MUL, SRC_K0,   SRC_CAA,   SRC_T};
      5'd22:   u = '{OP_SUB, SRC_CAA,  SRC_T,     SRC_CAA};
      5'd23:   u = '{OP_MUL, SRC_K0,   SRC_CAB,   SRC_T};
      5'd24:   u = '{OP_SUB, SRC_CAB,  SRC_T,     SRC_CAB};
      5'd25:   u = '{OP_MUL, SRC_K1,   SRC_CAA,   SRC_T};
      5'd26:   u = '{OP_SUB, SRC_CBA,  SRC_T,     SRC_CBA};
      5'd27:   u = '{OP_MUL, SRC_K1,   SRC_CAB,   SRC_T};
      5'd28:   u = '{OP_SUB, SRC_CBB,  SRC_T,     SRC_CBB};
      default: u = '{OP_DONE, SRC_NONE, SRC_NONE, SRC_NONE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: src/tak_mul.sv
// Fixed-point multiplier: four 24x24 partial products accumulated in turn.
// Depends on tak_pkg for the request and response types and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module tak_mul #(
  parameter int FRAC_BITS = 24
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tak_pkg::unit_req_t  req_i,
  output tak_pkg::unit_rsp_t  rsp_o
);

  logic [47:0] xm_q, ym_q;
  logic        neg_q;
  logic [95:0] acc_q, acc_d;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;

  logic [23:0] xa, yb;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  logic        hi;
  logic [46:0] p;

  // Pick the halves for this cycle's partial product and align it.
  always_comb begin
    xa = cnt_q[0] ? xm_q[47:24] : xm_q[23:0];
    yb = cnt_q[1] ? ym_q[47:24] : ym_q[23:0];
    pp = 48'(xa) * 48'(yb);
    case (cnt_q)
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
    acc_d = acc_q + pp_sh;
  end

  // Control of the accumulation sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand magnitudes and the product accumulator.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      xm_q  <= tak_pkg::mag48(req_i.a);
      ym_q  <= tak_pkg::mag48(req_i.b);
      neg_q <= req_i.a[47] ^ req_i.b[47];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  // Drop the fraction bits and saturate with the product's sign.
  always_comb begin
    hi = |acc_q[95:FRAC_BITS+47];
    p  = acc_q[FRAC_BITS+46:FRAC_BITS];
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.value = hi ? tak_pkg::MIN48 : 48'(48'd0 - {1'b0, p});
    end else begin
      rsp_o.value = hi ? tak_pkg::MAX48 : {1'b0, p};
    end
  end

endmodule

`default_nettype wire

// File: src/tak_div.sv
// Fixed-point divider: restoring division, one quotient bit per cycle.
// Depends on tak_pkg for the request and response types and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module tak_div #(
  parameter int FRAC_BITS = 24
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tak_pkg::unit_req_t  req_i,
  output tak_pkg::unit_rsp_t  rsp_o
);

  localparam int N  = 48 + FRAC_BITS;
  localparam int CW = $clog2(N);

  logic [N-1:0]  sreg_q;
  logic [47:0]   d_q, r_q, q_q;
  logic          ovf_q, zero_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  logic [48:0] r_sh, r_diff;
  logic        ge;
  logic        capped;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    r_sh   = {r_q, sreg_q[N-1]};
    r_diff = r_sh - {1'b0, d_q};
    ge     = (r_sh >= {1'b0, d_q});
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(N - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  // Dividend shift register, remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sreg_q <= N'({tak_pkg::mag48(req_i.a), {FRAC_BITS{1'b0}}});
      d_q    <= tak_pkg::mag48(req_i.b);
      r_q    <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
      zero_q <= (req_i.b == '0);
      neg_q  <= req_i.a[47] ^ req_i.b[47];
    end else if (busy_q) begin
      sreg_q <= sreg_q << 1;
      r_q    <= ge ? r_diff[47:0] : r_sh[47:0];
      q_q    <= {q_q[46:0], ge};
      ovf_q  <= ovf_q | q_q[47];
    end
  end

  // Saturate the quotient; a zero divisor gives zero.
  always_comb begin
    capped = ovf_q | q_q[47];
    rsp_o.done = done_q;
    if (zero_q) begin
      rsp_o.value = '0;
    end else if (neg_q) begin
      rsp_o.value = capped ? tak_pkg::MIN48 : 48'(48'd0 - q_q);
    end else begin
      rsp_o.value = capped ? tak_pkg::MAX48 : q_q;
    end
  end

endmodule

`default_nettype wire

// File: src/tilt_angle_kalman_filter_unit.sv
// Top level of the two-state tilt angle Kalman filter: sequencer, state and datapath.
// Depends on tak_pkg, tak_mul and tak_div.
//
//   Channel  Signals                                         Direction
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i                 in, write only
//   in       in_valid_i/in_ready_o, measured_angle_i,
//            gyro_rate_i, loop_ms_i                          in
//   out      out_valid_o/out_ready_i, angle_int_o,
//            angle_fixed_o                                   out
//
// A new input transfer is taken only after the step program of the last item has ended;
// the result is loaded into the output register at the end of the program.
// The two gain divisions run on the shared one-bit-per-cycle divider; the program
// also holds ten products on the multiplier and seventeen sums in the adder.
// Reset clears the estimates, the covariance and the registers to their defaults.
// A waiting result sits in the output register; the block accepts the next item
// meanwhile and stalls only at the end of that item if the result is still untaken.
`timescale 1ns / 1ps
`default_nettype none

module tilt_angle_kalman_filter_unit #(
  parameter int FRAC_BITS = 24
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [1:0]  cfg_idx_i,
  input  wire         [23:0] cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  signed [11:0] measured_angle_i,
  input  wire  signed [25:0] gyro_rate_i,
  input  wire         [9:0]  loop_ms_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] angle_int_o,
  output logic signed [47:0] angle_fixed_o
);

  localparam int UP = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int DN = (FRAC_BITS >= 24) ? 0 : 24 - FRAC_BITS;

  // Rounded-up reciprocal of 1000 with 20 extra bits; exact floor for loop times
  // below 1024 because 2^20 exceeds 1000 times the largest loop time.
  localparam longint unsigned DT_RECIP =
    ((64'd1 << (FRAC_BITS + 20)) + 64'd999) / 64'd1000;

  tak_pkg::state_e st_q, st_d;
  logic [4:0]      pc_q;
  tak_pkg::uop_t   uop;

  logic [23:0] cfg_qa_q, cfg_qb_q, cfg_rm_q;

  logic signed [47:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
  logic signed [47:0] dt_q, t_q, u_q, y_q, s_q, k0_q, k1_q, meas_q, rate_q;
  logic               out_valid_q;
  logic signed [15:0] out_int_q;
  logic signed [47:0] out_fixed_q;

  logic signed [47:0] qa, qb, rm, opa, opb, alu_res, wdata;
  logic signed [48:0] alu_sum;
  logic signed [63:0] rate_w;
  logic signed [47:0] rate_sat, meas_w, dt_w;
  logic        [63:0] dt_prod;
  logic [47:0]        ang_mag, ang_whole;
  logic signed [15:0] ang_int;

  tak_pkg::unit_req_t mul_req, div_req;
  tak_pkg::unit_rsp_t mul_rsp, div_rsp;

  logic accept, unit_done, wr_en, out_load, out_free;

  assign uop    = tak_pkg::uop_rom(pc_q);
  assign accept = in_valid_i & in_ready_o;

  // Noise registers rescaled to the working fraction width.
  assign qa = (48'(cfg_qa_q) << UP) >> DN;
  assign qb = (48'(cfg_qb_q) << UP) >> DN;
  assign rm = (48'(cfg_rm_q) << UP) >> DN;

  // Input conversion to fixed point at the transfer.
  always_comb begin
    meas_w = 48'(measured_angle_i) <<< FRAC_BITS;
    rate_w = 64'(gyro_rate_i) <<< (FRAC_BITS - 8);
    if (rate_w > 64'sh0000_7FFF_FFFF_FFFF) begin
      rate_sat = tak_pkg::MAX48;
    end else if (rate_w < 64'shFFFF_8000_0000_0000) begin
      rate_sat = tak_pkg::MIN48;
    end else begin
      rate_sat = rate_w[47:0];
    end
  end

  // Loop time in seconds: milliseconds times the reciprocal of 1000.
  assign dt_prod = 64'(loop_ms_i) * DT_RECIP;
  assign dt_w    = 48'(dt_prod >> 20);

  // First operand select.
  always_comb begin
    case (uop.src_a)
      tak_pkg::SRC_ANG:   opa = ang_q;
      tak_pkg::SRC_BIAS:  opa = bias_q;
      tak_pkg::SRC_CAA:   opa = caa_q;
      tak_pkg::SRC_CAB:   opa = cab_q;
      tak_pkg::SRC_CBA:   opa = cba_q;
      tak_pkg::SRC_CBB:   opa = cbb_q;
      tak_pkg::SRC_DT:    opa = dt_q;
      tak_pkg::SRC_T:     opa = t_q;
      tak_pkg::SRC_U:     opa = u_q;
      tak_pkg::SRC_Y:     opa = y_q;
      tak_pkg::SRC_S:     opa = s_q;
      tak_pkg::SRC_K0:    opa = k0_q;
      tak_pkg::SRC_K1:    opa = k1_q;
      tak_pkg::SRC_MEAS:  opa = meas_q;
      tak_pkg::SRC_RATE:  opa = rate_q;
      tak_pkg::SRC_QA:    opa = qa;
      tak_pkg::SRC_QB:    opa = qb;
      tak_pkg::SRC_RM:    opa = rm;
      default:            opa = '0;
    endcase
  end

  // Second operand select.
  always_comb begin
    case (uop.src_b)
      tak_pkg::SRC_ANG:   opb = ang_q;
      tak_pkg::SRC_BIAS:  opb = bias_q;
      tak_pkg::SRC_CAA:   opb = caa_q;
      tak_pkg::SRC_CAB:   opb = cab_q;
      tak_pkg::SRC_CBA:   opb = cba_q;
      tak_pkg::SRC_CBB:   opb = cbb_q;
      tak_pkg::SRC_DT:    opb = dt_q;
      tak_pkg::SRC_T:     opb = t_q;
      tak_pkg::SRC_U:     opb = u_q;
      tak_pkg::SRC_Y:     opb = y_q;
      tak_pkg::SRC_S:     opb = s_q;
      tak_pkg::SRC_K0:    opb = k0_q;
      tak_pkg::SRC_K1:    opb = k1_q;
      tak_pkg::SRC_MEAS:  opb = meas_q;
      tak_pkg::SRC_RATE:  opb = rate_q;
      tak_pkg::SRC_QA:    opb = qa;
      tak_pkg::SRC_QB:    opb = qb;
      tak_pkg::SRC_RM:    opb = rm;
      default:            opb = '0;
    endcase
  end

  // Saturating add and subtract.
  always_comb begin
    if (uop.op == tak_pkg::OP_SUB) begin
      alu_sum = {opa[47], opa} - {opb[47], opb};
    end else begin
      alu_sum = {opa[47], opa} + {opb[47], opb};
    end
    alu_res = tak_pkg::sat49(alu_sum);
  end

  // Angle truncated toward zero to whole units, saturated to 16 bits.
  always_comb begin
    ang_mag   = tak_pkg::mag48(ang_q);
    ang_whole = ang_mag >> FRAC_BITS;
    if (ang_q[47]) begin
      ang_int = (ang_whole > 48'd32768) ? 16'sh8000 : 16'(16'd0 - ang_whole[15:0]);
    end else begin
      ang_int = (ang_whole > 48'd32767) ? 16'sh7FFF : ang_whole[15:0];
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign unit_done = (uop.op == tak_pkg::OP_MUL) ? mul_rsp.done : div_rsp.done;

  // Next state of the sequencer.
  always_comb begin
    st_d = st_q;
    case (st_q)
      tak_pkg::ST_IDLE: begin
        if (in_valid_i) st_d = tak_pkg::ST_ISSUE;
      end
      tak_pkg::ST_ISSUE: begin
        case (uop.op)
          tak_pkg::OP_MUL, tak_pkg::OP_DIV: st_d = tak_pkg::ST_WAIT;
          tak_pkg::OP_DONE: begin
            if (out_free) st_d = tak_pkg::ST_IDLE;
          end
          default: st_d = tak_pkg::ST_ISSUE;
        endcase
      end
      tak_pkg::ST_WAIT: begin
        if (unit_done) st_d = tak_pkg::ST_ISSUE;
      end
      default: st_d = tak_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts, register write and result load.
  always_comb begin
    in_ready_o    = (st_q == tak_pkg::ST_IDLE);
    mul_req.start = (st_q == tak_pkg::ST_ISSUE) && (uop.op == tak_pkg::OP_MUL);
    mul_req.a     = opa;
    mul_req.b     = opb;
    div_req.start = (st_q == tak_pkg::ST_ISSUE) && (uop.op == tak_pkg::OP_DIV);
    div_req.a     = opa;
    div_req.b     = opb;
    wr_en         = 1'b0;
    wdata         = alu_res;
    out_load      = 1'b0;
    case (st_q)
      tak_pkg::ST_ISSUE: begin
        if (uop.op == tak_pkg::OP_ADD || uop.op == tak_pkg::OP_SUB) wr_en = 1'b1;
        if (uop.op == tak_pkg::OP_DONE) out_load = out_free;
      end
      tak_pkg::ST_WAIT: begin
        wr_en = unit_done;
        wdata = (uop.op == tak_pkg::OP_MUL) ? mul_rsp.value : div_rsp.value;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  tak_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  tak_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Control state, configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tak_pkg::ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      cfg_qa_q    <= tak_pkg::QA_RESET;
      cfg_qb_q    <= tak_pkg::QB_RESET;
      cfg_rm_q    <= tak_pkg::RM_RESET;
      ang_q       <= '0;
      bias_q      <= '0;
      caa_q       <= '0;
      cab_q       <= '0;
      cba_q       <= '0;
      cbb_q       <= '0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        pc_q <= '0;
      end else if (wr_en) begin
        pc_q <= pc_q + 5'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tak_pkg::CFG_QA: cfg_qa_q <= cfg_data_i;
          tak_pkg::CFG_QB: cfg_qb_q <= cfg_data_i;
          tak_pkg::CFG_RM: cfg_rm_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (wr_en) begin
        case (uop.dst)
          tak_pkg::SRC_ANG:  ang_q  <= wdata;
          tak_pkg::SRC_BIAS: bias_q <= wdata;
          tak_pkg::SRC_CAA:  caa_q  <= wdata;
          tak_pkg::SRC_CAB:  cab_q  <= wdata;
          tak_pkg::SRC_CBA:  cba_q  <= wdata;
          tak_pkg::SRC_CBB:  cbb_q  <= wdata;
          default: ;
        endcase
      end
    end
  end

  // Working values, captured inputs and the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= meas_w;
      rate_q <= rate_sat;
      dt_q   <= dt_w;
    end
    if (wr_en) begin
      case (uop.dst)
        tak_pkg::SRC_T:  t_q  <= wdata;
        tak_pkg::SRC_U:  u_q  <= wdata;
        tak_pkg::SRC_Y:  y_q  <= wdata;
        tak_pkg::SRC_S:  s_q  <= wdata;
        tak_pkg::SRC_K0: k0_q <= wdata;
        tak_pkg::SRC_K1: k1_q <= wdata;
        default: ;
      endcase
    end
    if (out_load) begin
      out_int_q   <= ang_int;
      out_fixed_q <= ang_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign angle_int_o   = out_int_q;
  assign angle_fixed_o = out_fixed_q;

endmodule

`default_nettype wire
